// ===== design/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// whp_pkg
// Shared constants and types for the RIFF/WAVE header parser: chunk tags,
// format limits, status codes and the result request passed to the
// output stage.
// ----------------------------------------------------------------------------
package whp_pkg;

    localparam logic [31:0] TAG_RIFF         = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE         = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT          = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA         = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_LEN      = 32'd16;
    localparam logic [31:0] CD_RATE          = 32'd44100;
    localparam logic [31:0] CD_BYTES_PER_SEC = 32'd176400;
    localparam logic [15:0] CD_CHANNELS      = 16'd2;
    localparam logic [15:0] CD_BITS          = 16'd16;
    localparam logic [32:0] RIFF_EXTRA       = 33'd8;
    localparam logic [31:0] POS_MAX          = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_RIFF   = 3'd1,
        ST_NO_WAVE   = 3'd2,
        ST_FMT_SHORT = 3'd3,
        ST_UNEXP_END = 3'd4,
        ST_NO_DATA   = 3'd5
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] data_size;
        logic [31:0] data_offset;
        logic [32:0] file_size;
    } result_req_t;

endpackage

// ===== design/whp_result.sv =====
// ----------------------------------------------------------------------------
// whp_result
// Result register of the header parser. Unpacks the little-endian format
// fields, derives the CD-quality flag and holds one request until taken.
// ----------------------------------------------------------------------------
module whp_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  whp_pkg::result_req_t req,
    input  logic [15:0][7:0]     fmt,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [2:0]           status,
    output logic [15:0]          audio_format,
    output logic [15:0]          channel_count,
    output logic [31:0]          sample_rate,
    output logic [31:0]          byte_rate,
    output logic [15:0]          block_align,
    output logic [15:0]          sample_bits,
    output logic [31:0]          data_size,
    output logic [31:0]          data_offset,
    output logic [32:0]          file_size,
    output logic                 cd_quality
);
    import whp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [2:0]  status_reg;
    logic [15:0] format_reg;
    logic [15:0] channels_reg;
    logic [31:0] rate_reg;
    logic [31:0] brate_reg;
    logic [15:0] align_reg;
    logic [15:0] bits_reg;
    logic [31:0] dsize_reg;
    logic [31:0] offset_reg;
    logic [32:0] fsize_reg;
    logic        cd_reg;

    logic        ok;
    logic [15:0] ch_w;
    logic [31:0] rate_w;
    logic [31:0] brate_w;
    logic [15:0] bits_w;

    assign ok      = (req.status == ST_OK);
    assign ch_w    = {fmt[3], fmt[2]};
    assign rate_w  = {fmt[7], fmt[6], fmt[5], fmt[4]};
    assign brate_w = {fmt[11], fmt[10], fmt[9], fmt[8]};
    assign bits_w  = {fmt[15], fmt[14]};

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg   <= req.status;
            format_reg   <= ok ? {fmt[1], fmt[0]} : 16'd0;
            channels_reg <= ok ? ch_w : 16'd0;
            rate_reg     <= ok ? rate_w : 32'd0;
            brate_reg    <= ok ? brate_w : 32'd0;
            align_reg    <= ok ? {fmt[13], fmt[12]} : 16'd0;
            bits_reg     <= ok ? bits_w : 16'd0;
            dsize_reg    <= ok ? req.data_size : 32'd0;
            offset_reg   <= ok ? req.data_offset : 32'd0;
            fsize_reg    <= ok ? req.file_size : 33'd0;
            cd_reg       <= ok && (ch_w == CD_CHANNELS) && (bits_w == CD_BITS)
                            && (rate_w == CD_RATE) && (brate_w == CD_BYTES_PER_SEC);
        end
    end

    assign out_valid     = valid_reg;
    assign status        = status_reg;
    assign audio_format  = format_reg;
    assign channel_count = channels_reg;
    assign sample_rate   = rate_reg;
    assign byte_rate     = brate_reg;
    assign block_align   = align_reg;
    assign sample_bits   = bits_reg;
    assign data_size     = dsize_reg;
    assign data_offset   = offset_reg;
    assign file_size     = fsize_reg;
    assign cd_quality    = cd_reg;

endmodule

// ===== design/wav_header_parser.sv =====
// ----------------------------------------------------------------------------
// wav_header_parser
// Parses a RIFF/WAVE header one byte per request and emits one result with
// the format fields, data chunk size and offset, or an error status.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_ready   data_byte, end_of_stream
//   output   out        out_valid / out_ready status .. cd_quality
//
// One byte is taken every cycle unless in_ready is low; a byte is parsed in
// the cycle it is taken and its result, if any, appears in the result
// register on the next cycle. A held result only blocks input while
// out_ready is low. Reset returns the parser to the RIFF tag search; so
// does a byte flagged end_of_stream, after that byte is parsed.
// ----------------------------------------------------------------------------
module wav_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] audio_format,
    output logic [15:0] channel_count,
    output logic [31:0] sample_rate,
    output logic [31:0] byte_rate,
    output logic [15:0] block_align,
    output logic [15:0] sample_bits,
    output logic [31:0] data_size,
    output logic [31:0] data_offset,
    output logic [32:0] file_size,
    output logic        cd_quality
);
    import whp_pkg::*;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_SIZE,
        PH_WAVE,
        PH_CTAG,
        PH_CLEN,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    phase_t           phase_reg,  phase_next;
    logic [1:0]       idx_reg,    idx_next;
    logic [23:0]      asm_reg,    asm_next;
    logic [31:0]      tag_reg,    tag_next;
    logic [31:0]      len_reg,    len_next;
    logic [31:0]      skip_reg,   skip_next;
    logic [31:0]      pos_reg,    pos_next;
    logic [15:0][7:0] fmt_reg,    fmt_next;
    logic [32:0]      riff_reg,   riff_next;

    logic             acc;
    logic             res_load;
    result_req_t      req;
    logic [31:0]      word;
    logic [4:0]       fmt_sum;
    logic [3:0]       fmt_idx;
    logic             err;
    status_t          err_code;
    logic             boundary;

    assign in_ready = !out_valid || out_ready;
    assign acc      = in_valid && in_ready;
    assign word     = {data_byte, asm_reg};
    assign fmt_sum  = 5'd16 - skip_reg[4:0];
    assign fmt_idx  = fmt_sum[3:0];

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        asm_next   = asm_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        skip_next  = skip_reg;
        pos_next   = pos_reg;
        fmt_next   = fmt_reg;
        riff_next  = riff_reg;
        res_load   = 1'b0;
        req        = '0;
        err        = 1'b0;
        err_code   = ST_OK;
        boundary   = 1'b0;

        if (acc && (phase_reg != PH_DONE))
        begin
            pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 32'd1;

            unique case (phase_reg)
                PH_RIFF, PH_SIZE, PH_WAVE, PH_CTAG, PH_CLEN:
                begin
                    asm_next = {data_byte, asm_reg[23:8]};
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        unique case (phase_reg)
                            PH_RIFF:
                            begin
                                if (word != TAG_RIFF)
                                begin
                                    err      = 1'b1;
                                    err_code = ST_NO_RIFF;
                                end
                                else
                                begin
                                    phase_next = PH_SIZE;
                                end
                            end
                            PH_SIZE:
                            begin
                                riff_next  = {1'b0, word} + RIFF_EXTRA;
                                phase_next = PH_WAVE;
                            end
                            PH_WAVE:
                            begin
                                if (word != TAG_WAVE)
                                begin
                                    err      = 1'b1;
                                    err_code = ST_NO_WAVE;
                                end
                                else
                                begin
                                    phase_next = PH_CTAG;
                                end
                            end
                            PH_CTAG:
                            begin
                                tag_next   = word;
                                phase_next = PH_CLEN;
                            end
                            default:
                            begin
                                len_next = word;
                                if (tag_reg == TAG_FMT)
                                begin
                                    if (word < FMT_MIN_LEN)
                                    begin
                                        err      = 1'b1;
                                        err_code = ST_FMT_SHORT;
                                    end
                                    else
                                    begin
                                        skip_next  = FMT_MIN_LEN;
                                        phase_next = PH_FMT;
                                    end
                                end
                                else if (tag_reg == TAG_DATA)
                                begin
                                    res_load        = 1'b1;
                                    req.status      = ST_OK;
                                    req.data_size   = word;
                                    req.data_offset = pos_next;
                                    req.file_size   = riff_reg;
                                    phase_next      = PH_DONE;
                                end
                                else
                                begin
                                    skip_next  = word;
                                    phase_next = (word != 32'd0) ? PH_SKIP : PH_CTAG;
                                end
                            end
                        endcase
                    end
                end
                PH_FMT:
                begin
                    fmt_next[fmt_idx] = data_byte;
                    skip_next         = skip_reg - 32'd1;
                    if (skip_reg == 32'd1)
                    begin
                        skip_next  = len_reg - FMT_MIN_LEN;
                        phase_next = (len_reg != FMT_MIN_LEN) ? PH_SKIP : PH_CTAG;
                    end
                end
                default:
                begin
                    if (skip_reg <= 32'd1)
                    begin
                        skip_next  = 32'd0;
                        phase_next = PH_CTAG;
                    end
                    else
                    begin
                        skip_next = skip_reg - 32'd1;
                    end
                end
            endcase

            if (err)
            begin
                res_load   = 1'b1;
                req        = '0;
                req.status = err_code;
                phase_next = PH_DONE;
            end
            else if ((phase_next != PH_DONE) && end_of_stream)
            begin
                boundary   = ((phase_next == PH_CTAG) && (idx_next == 2'd0))
                             || (phase_next == PH_SKIP);
                res_load   = 1'b1;
                req        = '0;
                req.status = boundary ? ST_NO_DATA : ST_UNEXP_END;
                phase_next = PH_DONE;
            end
        end

        if (acc && end_of_stream)
        begin
            phase_next = PH_RIFF;
            idx_next   = 2'd0;
            asm_next   = 24'd0;
            tag_next   = 32'd0;
            len_next   = 32'd0;
            skip_next  = 32'd0;
            pos_next   = 32'd0;
            fmt_next   = '0;
            riff_next  = 33'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            idx_reg   <= 2'd0;
            asm_reg   <= 24'd0;
            tag_reg   <= 32'd0;
            len_reg   <= 32'd0;
            skip_reg  <= 32'd0;
            pos_reg   <= 32'd0;
            fmt_reg   <= '0;
            riff_reg  <= 33'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            asm_reg   <= asm_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            fmt_reg   <= fmt_next;
            riff_reg  <= riff_next;
        end
    end

    whp_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_load),
        .req           (req),
        .fmt           (fmt_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .status        (status),
        .audio_format  (audio_format),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .byte_rate     (byte_rate),
        .block_align   (block_align),
        .sample_bits   (sample_bits),
        .data_size     (data_size),
        .data_offset   (data_offset),
        .file_size     (file_size),
        .cd_quality    (cd_quality)
    );

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("Parser stalls input with an empty result register.");

    a_eos_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && end_of_stream) |=> (phase_reg == PH_RIFF) && (pos_reg == 32'd0))
        else $error("End of stream did not re-arm the parser.");

    a_result_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && !end_of_stream) |=> (phase_reg == PH_DONE) && out_valid)
        else $error("A result did not stop the parse.");

    a_fmt_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FMT) |-> (skip_reg != 32'd0) && (skip_reg <= FMT_MIN_LEN))
        else $error("Format byte counter out of range.");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_reg != 32'd0))
        else $error("Skip phase entered with nothing to skip.");
`endif

endmodule

// ===== dv/wav_header_checker.sv =====
// ----------------------------------------------------------------------------
// wav_header_checker
// Watches both request channels of the WAV header parser. Every accepted
// byte is run through a local copy of the parsing rules, and every accepted
// result is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module wav_header_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [15:0] audio_format,
    input  logic [15:0] channel_count,
    input  logic [31:0] sample_rate,
    input  logic [31:0] byte_rate,
    input  logic [15:0] block_align,
    input  logic [15:0] sample_bits,
    input  logic [31:0] data_size,
    input  logic [31:0] data_offset,
    input  logic [32:0] file_size,
    input  logic        cd_quality,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import whp_pkg::*;

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_SIZE,
        PH_WAVE,
        PH_CTAG,
        PH_CLEN,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] data_size;
        logic [31:0] data_offset;
        logic [32:0] file_size;
        logic        cd_quality;
    } wav_result_t;

    parse_phase_t phase;
    int           byte_idx;
    logic [31:0]  word_acc;
    logic [31:0]  chunk_id;
    logic [31:0]  chunk_len;
    logic [31:0]  skip_left;
    logic [31:0]  position;
    logic [7:0]   fmt_bytes [16];
    logic [32:0]  riff_total;

    wav_result_t  expected_results [$];

    function automatic logic [15:0] fmt_half(input int i);
        return {fmt_bytes[4'(i + 1)], fmt_bytes[4'(i)]};
    endfunction

    function automatic logic [31:0] fmt_word(input int i);
        return {fmt_half(i + 2), fmt_half(i)};
    endfunction

    function automatic wav_result_t make_result(input status_t st, input logic [31:0] dsize);
        wav_result_t r;
        r = '0;
        r.status = st;
        if (st == ST_OK)
        begin
            r.audio_format  = fmt_half(0);
            r.channel_count = fmt_half(2);
            r.sample_rate   = fmt_word(4);
            r.byte_rate     = fmt_word(8);
            r.block_align   = fmt_half(12);
            r.sample_bits   = fmt_half(14);
            r.data_size     = dsize;
            r.data_offset   = position;
            r.file_size     = riff_total;
            r.cd_quality    = (r.channel_count == CD_CHANNELS) && (r.sample_bits == CD_BITS) &&
                              (r.sample_rate == CD_RATE) &&
                              (r.byte_rate == CD_BYTES_PER_SEC);
        end
        return r;
    endfunction

    task automatic clear_parser();
        phase      = PH_RIFF;
        byte_idx   = 0;
        word_acc   = '0;
        chunk_id   = '0;
        chunk_len  = '0;
        skip_left  = '0;
        position   = '0;
        riff_total = '0;
        foreach (fmt_bytes[i])
            fmt_bytes[i] = 8'h00;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eos);
        logic [31:0] w;
        bit          failed;
        status_t     err;
        bit          boundary;
        failed = 1'b0;
        err    = ST_OK;
        if (phase != PH_DONE)
        begin
            if (position != POS_MAX)
                position = position + 1;
            if (phase <= PH_CLEN)
            begin
                word_acc = word_acc | (32'(b) << (8 * byte_idx));
                byte_idx++;
                if (byte_idx == 4)
                begin
                    w        = word_acc;
                    byte_idx = 0;
                    word_acc = '0;
                    case (phase)
                        PH_RIFF:
                        begin
                            if (w != TAG_RIFF)
                            begin
                                failed = 1'b1;
                                err    = ST_NO_RIFF;
                            end
                            else
                                phase = PH_SIZE;
                        end
                        PH_SIZE:
                        begin
                            riff_total = {1'b0, w} + RIFF_EXTRA;
                            phase      = PH_WAVE;
                        end
                        PH_WAVE:
                        begin
                            if (w != TAG_WAVE)
                            begin
                                failed = 1'b1;
                                err    = ST_NO_WAVE;
                            end
                            else
                                phase = PH_CTAG;
                        end
                        PH_CTAG:
                        begin
                            chunk_id = w;
                            phase    = PH_CLEN;
                        end
                        default:
                        begin
                            chunk_len = w;
                            if (chunk_id == TAG_FMT)
                            begin
                                if (w < FMT_MIN_LEN)
                                begin
                                    failed = 1'b1;
                                    err    = ST_FMT_SHORT;
                                end
                                else
                                begin
                                    skip_left = FMT_MIN_LEN;
                                    phase     = PH_FMT;
                                end
                            end
                            else if (chunk_id == TAG_DATA)
                            begin
                                expected_results.push_back(make_result(ST_OK, w));
                                phase = PH_DONE;
                            end
                            else
                            begin
                                skip_left = w;
                                if (w != 0)
                                    phase = PH_SKIP;
                                else
                                    phase = PH_CTAG;
                            end
                        end
                    endcase
                end
            end
            else if (phase == PH_FMT)
            begin
                fmt_bytes[4'(FMT_MIN_LEN - skip_left)] = b;
                skip_left = skip_left - 1;
                if (skip_left == 0)
                begin
                    skip_left = chunk_len - FMT_MIN_LEN;
                    if (skip_left != 0)
                        phase = PH_SKIP;
                    else
                        phase = PH_CTAG;
                end
            end
            else
            begin
                if (skip_left != 0)
                    skip_left = skip_left - 1;
                if (skip_left == 0)
                    phase = PH_CTAG;
            end

            if (failed)
            begin
                expected_results.push_back(make_result(err, '0));
                phase = PH_DONE;
            end
            else if (phase != PH_DONE && eos)
            begin
                boundary = (phase == PH_CTAG && byte_idx == 0) || phase == PH_SKIP;
                if (boundary)
                    expected_results.push_back(make_result(ST_NO_DATA, '0));
                else
                    expected_results.push_back(make_result(ST_UNEXP_END, '0));
                phase = PH_DONE;
            end
        end
        if (eos)
            clear_parser();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        wav_result_t want;
        if (!rst_n)
        begin
            mismatches  = 0;
            outstanding = 0;
            expected_results.delete();
            clear_parser();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with status %0d arrived when none was due",
                                 $time, status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("audio_format", want.audio_format, audio_format);
                    check_field("channel_count", want.channel_count, channel_count);
                    check_field("sample_rate", want.sample_rate, sample_rate);
                    check_field("byte_rate", want.byte_rate, byte_rate);
                    check_field("block_align", want.block_align, block_align);
                    check_field("sample_bits", want.sample_bits, sample_bits);
                    check_field("data_size", want.data_size, data_size);
                    check_field("data_offset", want.data_offset, data_offset);
                    check_field("file_size", want.file_size, file_size);
                    check_field("cd_quality", want.cd_quality, cd_quality);
                end
            end
            if (in_valid && in_ready)
                parse_byte(data_byte, end_of_stream);
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== dv/tb_wav_header_parser.sv =====
// ----------------------------------------------------------------------------
// tb_wav_header_parser
// Feeds the WAV header parser with directed and randomly built files, some
// well formed and some broken or cut short, under random input gaps and
// output stalls, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_wav_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import whp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
    logic [31:0] data_offset;
    logic [32:0] file_size;
    logic        cd_quality;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    logic [7:0]  wav_bytes [$];

    always #5 clk = ~clk;

    wav_header_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .audio_format  (audio_format),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .byte_rate     (byte_rate),
        .block_align   (block_align),
        .sample_bits   (sample_bits),
        .data_size     (data_size),
        .data_offset   (data_offset),
        .file_size     (file_size),
        .cd_quality    (cd_quality)
    );

    wav_header_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .audio_format  (audio_format),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .byte_rate     (byte_rate),
        .block_align   (block_align),
        .sample_bits   (sample_bits),
        .data_size     (data_size),
        .data_offset   (data_offset),
        .file_size     (file_size),
        .cd_quality    (cd_quality),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // The result side alternates between always ready, coin-flip ready and
    // long stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(20, 200);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic put_half(input logic [15:0] h);
        wav_bytes.push_back(h[7:0]);
        wav_bytes.push_back(h[15:8]);
    endtask

    task automatic put_word(input logic [31:0] w);
        put_half(w[15:0]);
        put_half(w[31:16]);
    endtask

    task automatic put_noise(input int n);
        repeat (n)
            wav_bytes.push_back(8'($urandom));
    endtask

    task automatic put_header(input logic [31:0] riff_size);
        put_word(TAG_RIFF);
        put_word(riff_size);
        put_word(TAG_WAVE);
    endtask

    task automatic put_fmt_fields(input logic [15:0] fmt_code, input logic [15:0] chans,
                                  input logic [31:0] rate, input logic [31:0] brate,
                                  input logic [15:0] align, input logic [15:0] bits);
        put_half(fmt_code);
        put_half(chans);
        put_word(rate);
        put_word(brate);
        put_half(align);
        put_half(bits);
    endtask

    task automatic put_random_fmt();
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] brate;
        if ($urandom_range(0, 2) == 0)
        begin
            chans = CD_CHANNELS;
            bits  = CD_BITS;
            rate  = CD_RATE;
            brate = CD_BYTES_PER_SEC;
            case ($urandom_range(0, 7))
                0:       chans = chans - 16'd1;
                1:       bits  = bits + 16'd8;
                2:       rate  = rate + 32'd1;
                3:       brate = brate ^ (32'd1 << $urandom_range(0, 31));
                default: ;
            endcase
            put_fmt_fields(16'd1, chans, rate, brate, 16'd4, bits);
        end
        else
            put_fmt_fields(pick16(), pick16(), pick32(), pick32(), pick16(), pick16());
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file();
        if (wav_bytes.size() == 0)
            wav_bytes.push_back(8'($urandom));
        foreach (wav_bytes[i])
            push_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        files_sent++;
        wav_bytes.delete();
    endtask

    task automatic run_directed();
        // End of stream on the very first byte.
        wav_bytes.push_back(8'h52);
        send_file();

        // Bad RIFF tag, followed by bytes that must be ignored.
        put_word(TAG_RIFF ^ 32'h0400_0000);
        put_noise(2);
        send_file();

        // Bad WAVE tag with the largest RIFF size.
        put_word(TAG_RIFF);
        put_word(32'hFFFF_FFFF);
        put_word(TAG_WAVE ^ 32'h0000_0001);
        send_file();

        // Stream ends right after the WAVE tag, on a chunk boundary.
        put_header(32'h0);
        send_file();

        // A fmt chunk that is too short.
        put_header(32'd100);
        put_word(TAG_FMT);
        put_word(32'd15);
        put_noise(1);
        send_file();

        // CD-quality format, largest data size, stream ends on the result byte.
        put_header(32'hFFFF_FFFF);
        put_word(TAG_FMT);
        put_word(FMT_MIN_LEN);
        put_fmt_fields(16'd1, CD_CHANNELS, CD_RATE, CD_BYTES_PER_SEC, 16'd4, CD_BITS);
        put_word(TAG_DATA);
        put_word(32'hFFFF_FFFF);
        send_file();

        // Long fmt with all-ones fields, an empty unknown chunk, empty data.
        put_header(32'h0);
        put_word(TAG_FMT);
        put_word(32'd18);
        put_fmt_fields(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        put_noise(2);
        put_word(32'h5453_494C);
        put_word(32'h0);
        put_word(TAG_DATA);
        put_word(32'h0);
        put_noise(3);
        send_file();

        // Stream ends inside a skip that runs past the end.
        put_header(32'd36);
        put_word(32'h6B6E_756A);
        put_word(32'h7FFF_FFFF);
        put_noise(3);
        send_file();

        // Stream ends in the middle of a chunk tag.
        put_header(32'd36);
        wav_bytes.push_back(8'h64);
        wav_bytes.push_back(8'h61);
        send_file();

        // Stream ends inside the fmt body.
        put_header(32'd36);
        put_word(TAG_FMT);
        put_word(FMT_MIN_LEN);
        put_noise(7);
        send_file();
    endtask

    task automatic build_random_file();
        int          kind;
        int          n_chunks;
        int          len;
        int          cut;
        logic [31:0] chunk_tag;
        kind = $urandom_range(0, 99);
        if (kind < 4)
            put_noise($urandom_range(1, 12));
        else
        begin
            if (kind < 8)
                put_word(TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
            else
                put_word(TAG_RIFF);
            put_word(pick32());
            if (kind >= 8 && kind < 12)
                put_word(TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)));
            else
                put_word(TAG_WAVE);
            n_chunks = $urandom_range(0, 3);
            for (int c = 0; c < n_chunks; c++)
            begin
                case ($urandom_range(0, 11))
                    0:
                    begin
                        put_word(TAG_FMT);
                        put_word($urandom_range(0, 15));
                    end
                    1, 2, 3:
                    begin
                        if ($urandom_range(0, 1) == 0)
                            chunk_tag = TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
                        else
                            chunk_tag = $urandom;
                        len = $urandom_range(0, 10);
                        put_word(chunk_tag);
                        put_word(len);
                        put_noise(len);
                    end
                    4:
                    begin
                        put_word($urandom);
                        put_word(32'h8000_0000 | $urandom);
                        put_noise($urandom_range(0, 6));
                    end
                    default:
                    begin
                        len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : 16;
                        put_word(TAG_FMT);
                        put_word(len);
                        put_random_fmt();
                        put_noise(len - 16);
                    end
                endcase
            end
            if ($urandom_range(0, 7) != 0)
            begin
                put_word(TAG_DATA);
                put_word(pick32());
                put_noise($urandom_range(0, 4));
            end
        end
        if ($urandom_range(0, 6) == 0)
        begin
            cut = $urandom_range(1, wav_bytes.size());
            while (wav_bytes.size() > cut)
                void'(wav_bytes.pop_back());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        end_of_stream = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        while (bytes_sent < 1400)
        begin
            build_random_file();
            send_file();
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
